// ===== hw/rtl/spo2_pkg.sv =====
// Shared types and constants for the SpO2 window ratio estimator.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package spo2_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int DC_W       = 34;
  localparam int DEV_W      = 27;
  localparam int SQ_W       = 2 * DEV_W;
  localparam int SUM_W      = 63;
  localparam int CNT_W      = 11;
  localparam int WINDOW_MAX = 1024;
  localparam int RATIO_W    = 18;
  localparam int RSAT_W     = 23;
  localparam int DIV_W      = 64;
  localparam int DEN_W      = 34;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Register indexes of the configuration port
  localparam logic [2:0] REG_WINDOW     = 3'd0;
  localparam logic [2:0] REG_DC_KEEP    = 3'd1;
  localparam logic [2:0] REG_SPO2_KEEP  = 3'd2;
  localparam logic [2:0] REG_DC_MIN     = 3'd3;
  localparam logic [2:0] REG_ACDC_CLAMP = 3'd4;
  localparam logic [2:0] REG_MIN_ACDC   = 3'd5;
  localparam logic [2:0] REG_LOW_LIMIT  = 3'd6;

  typedef struct packed {
    logic [10:0] window_samples;
    logic [15:0] dc_keep;
    logic [15:0] spo2_keep;
    logic [17:0] dc_min;
    logic [17:0] acdc_clamp;
    logic [17:0] min_acdc;
    logic [6:0]  low_limit;
  } cfg_t;

  // One closed window handed from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] ir_sum;
    logic [DC_W-1:0]  red_dc;
    logic [DC_W-1:0]  ir_dc;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spo2_front.sv =====
// Sample front end: DC trackers, squared-deviation sums and window close.
// Depends on spo2_pkg; pushes closed windows into spo2_fifo.
`default_nettype none

module spo2_front (
  input  logic                            clk,
  input  logic                            rst,
  input  spo2_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [spo2_pkg::SAMPLE_W-1:0]   red_sample,
  input  logic [spo2_pkg::SAMPLE_W-1:0]   ir_sample,
  output logic                            push,
  output spo2_pkg::job_t                  push_job,
  input  logic                            fifo_full
);
  import spo2_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_DC, F_DEV, F_SQ, F_ACC, F_PUSH} fstate_t;

  fstate_t             state;
  logic [SAMPLE_W-1:0] red_s, ir_s;
  logic [DC_W-1:0]     red_dc, ir_dc;
  logic [49:0]         red_pk, ir_pk;
  logic [34:0]         red_px, ir_px;
  logic [DEV_W-1:0]    red_dev, ir_dev;
  logic [SQ_W-1:0]     red_sq, ir_sq;
  logic [SUM_W-1:0]    red_sum, ir_sum;
  logic [CNT_W-1:0]    count;

  logic [16:0]         new_w;
  logic [CNT_W-1:0]    count_next, win;
  logic                close;

  function automatic logic [DC_W-1:0] dc_upd(input logic [49:0] pk, input logic [34:0] px);
    logic [50:0] acc;
    acc = {1'b0, pk} + {px, 16'h0} + 51'd32768;
    return acc[49:16];
  endfunction

  function automatic logic [DEV_W-1:0] dev_of(input logic [SAMPLE_W-1:0] s,
                                               input logic [DC_W-1:0] dc);
    logic [DC_W-1:0] x, mag;
    logic [DC_W:0]   rnd;
    x   = {s, 16'h0};
    mag = (x >= dc) ? x - dc : dc - x;
    rnd = {1'b0, mag} + (DC_W+1)'(128);
    return rnd[DC_W:8];
  endfunction

  assign new_w      = 17'h10000 - {1'b0, cfg.dc_keep};
  assign count_next = count + CNT_W'(1);

  always_comb begin
    if (cfg.window_samples == '0) begin
      win = CNT_W'(1);
    end else if (cfg.window_samples > CNT_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = cfg.window_samples;
    end
  end

  assign close    = (count_next >= win);
  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !fifo_full;
  assign push_job = '{red_sum: red_sum, ir_sum: ir_sum, red_dc: red_dc, ir_dc: ir_dc,
                      count: count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      red_dc  <= '0;
      ir_dc   <= '0;
      red_sum <= '0;
      ir_sum  <= '0;
      count   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            red_s <= red_sample;
            ir_s  <= ir_sample;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          red_pk <= red_dc * cfg.dc_keep;
          ir_pk  <= ir_dc * cfg.dc_keep;
          red_px <= red_s * new_w;
          ir_px  <= ir_s * new_w;
          state  <= F_DC;
        end
        F_DC: begin
          red_dc <= dc_upd(red_pk, red_px);
          ir_dc  <= dc_upd(ir_pk, ir_px);
          state  <= F_DEV;
        end
        F_DEV: begin
          red_dev <= dev_of(red_s, red_dc);
          ir_dev  <= dev_of(ir_s, ir_dc);
          state   <= F_SQ;
        end
        F_SQ: begin
          red_sq <= red_dev * red_dev;
          ir_sq  <= ir_dev * ir_dev;
          state  <= F_ACC;
        end
        F_ACC: begin
          red_sum <= red_sum + SUM_W'(red_sq);
          ir_sum  <= ir_sum + SUM_W'(ir_sq);
          count   <= count_next;
          state   <= close ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!fifo_full) begin
            red_sum <= '0;
            ir_sum  <= '0;
            count   <= '0;
            state   <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spo2_fifo.sv =====
// Short queue of closed windows between the front and the back.
// Depends on spo2_pkg for job_t and the queue depth.
`default_nettype none

module spo2_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  spo2_pkg::job_t push_job,
  input  logic           pop,
  output spo2_pkg::job_t pop_job,
  output logic           empty,
  output logic           full
);
  import spo2_pkg::*;

  job_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   fill;

  assign empty   = (fill == '0);
  assign full    = (fill == (PTR_W+1)'(FIFO_DEPTH));
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spo2_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on spo2_pkg for the request and response structs.
`default_nettype none

module spo2_div (
  input  logic               clk,
  input  logic               rst,
  input  spo2_pkg::div_req_t req,
  output spo2_pkg::div_rsp_t rsp
);
  import spo2_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy, done;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  rem, den;
  logic [DIV_W-1:0]  quo;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, den});
  assign rsp   = '{done: done, quo: quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        quo  <= {quo[DIV_W-2:0], fits};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spo2_back.sv =====
// Window back end: RMS, AC/DC ratios, R, linear SpO2, smoothing and output.
// Depends on spo2_pkg; drives spo2_div and pops spo2_fifo.
`default_nettype none

module spo2_back (
  input  logic               clk,
  input  logic               rst,
  input  spo2_pkg::cfg_t     cfg,
  input  logic               fifo_empty,
  input  spo2_pkg::job_t     fifo_job,
  output logic               pop,
  output spo2_pkg::div_req_t div_req,
  input  spo2_pkg::div_rsp_t div_rsp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         spo2_percent,
  output logic               spo2_ok,
  output logic signed [19:0] smoothed_spo2_q8,
  output logic signed [19:0] raw_spo2_q8,
  output logic signed [18:0] red_acdc_q16,
  output logic signed [18:0] ir_acdc_q16
);
  import spo2_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_MEAN, B_SQRT, B_ACDC, B_RATIO, B_RAW, B_RAW_W, B_MUL, B_SUM, B_OUT
  } bstate_t;

  localparam logic [RSAT_W-1:0] R_SAT     = RSAT_W'(64 << 16);
  // ceil(2^29 / 25): exact floor division by 25 for dividends below 2^24
  localparam logic [24:0]       RECIP_25  = 25'd21474837;
  localparam logic [DIV_W-1:0]  SQRT_TOP  = DIV_W'(1) << 62;

  bstate_t             state;
  job_t                job;
  logic                comp, ch, neg;
  logic [RATIO_W-1:0]  rr, ri;
  logic [RSAT_W-1:0]   r;
  logic signed [19:0]  raw, smoothed;
  logic [6:0]          held;
  logic signed [36:0]  p1;
  logic signed [37:0]  p2;
  logic [DIV_W-1:0]    sq_v, sq_res, sq_bit;
  logic [4:0]          sq_cnt;
  logic [48:0]         raw_prod;

  logic                job_ok;
  logic [DIV_W-1:0]    sq_trial, sq_res_next;
  logic [DC_W-1:0]     cur_dc;
  logic [RATIO_W-1:0]  clamped;
  logic signed [35:0]  rawnum;
  logic [35:0]         rawmag;
  logic [16:0]         new_w;
  logic signed [38:0]  ssum;
  logic                valid_now;
  logic [20:0]         held_rnd;
  logic                load;

  assign job_ok = (fifo_job.red_dc > {cfg.dc_min, 16'h0})
               && (fifo_job.ir_dc > {cfg.dc_min, 16'h0})
               && (fifo_job.ir_sum != '0);
  assign pop    = (state == B_IDLE) && !fifo_empty;

  // One step of the bitwise integer square root
  assign sq_trial    = sq_res + sq_bit;
  assign sq_res_next = (sq_v >= sq_trial) ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  assign cur_dc      = ch ? job.ir_dc : job.red_dc;
  assign clamped     = (div_rsp.quo > DIV_W'(cfg.acdc_clamp)) ? cfg.acdc_clamp
                                                               : div_rsp.quo[RATIO_W-1:0];

  // 100 - 23.3*(R-0.4) in Q.8, with the rounding half folded in
  assign rawnum = 36'sd358226176 - $signed({13'b0, r}) * 36'sd1165;
  assign rawmag = rawnum[35] ? 36'(-rawnum + 36'sd12799) : rawnum;

  assign new_w     = 17'h10000 - {1'b0, cfg.spo2_keep};
  assign ssum      = 39'(p1) + 39'(p2) + 39'sd32768;
  assign valid_now = comp
                  && (smoothed > $signed({5'b0, cfg.low_limit, 8'h0}))
                  && (smoothed <= 20'sd25600)
                  && (rr >= cfg.min_acdc) && (ri >= cfg.min_acdc);
  assign held_rnd  = 21'(smoothed) + 21'sd128;
  assign load      = (state == B_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      smoothed      <= '0;
      held          <= '0;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      out_valid     <= load || (out_valid && out_stall);
      unique case (state)
        B_IDLE: begin
          if (!fifo_empty) begin
            job  <= fifo_job;
            comp <= job_ok;
            ch   <= 1'b0;
            if (job_ok) begin
              div_req <= '{start: 1'b1, num: DIV_W'(fifo_job.red_sum),
                           den: DEN_W'(fifo_job.count)};
              state   <= B_MEAN;
            end else begin
              state <= B_OUT;
            end
          end
        end
        B_MEAN: begin
          if (div_rsp.done) begin
            sq_v   <= div_rsp.quo;
            sq_res <= '0;
            sq_bit <= SQRT_TOP;
            sq_cnt <= '0;
            state  <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (sq_v >= sq_trial) begin
            sq_v <= sq_v - sq_trial;
          end
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd31) begin
            div_req <= '{start: 1'b1,
                         num: {sq_res_next[39:0], 24'h0} + DIV_W'(cur_dc >> 1),
                         den: cur_dc};
            state   <= B_ACDC;
          end
        end
        B_ACDC: begin
          if (div_rsp.done) begin
            if (!ch) begin
              rr      <= clamped;
              ch      <= 1'b1;
              div_req <= '{start: 1'b1, num: DIV_W'(job.ir_sum), den: DEN_W'(job.count)};
              state   <= B_MEAN;
            end else begin
              ri <= clamped;
              if (clamped == '0) begin
                // IR ratio of zero: saturate R unless red is zero too
                r     <= (rr == '0) ? '0 : R_SAT;
                state <= B_RAW;
              end else begin
                div_req <= '{start: 1'b1,
                             num: DIV_W'({rr, 16'h0}) + DIV_W'(clamped >> 1),
                             den: DEN_W'(clamped)};
                state   <= B_RATIO;
              end
            end
          end
        end
        B_RATIO: begin
          if (div_rsp.done) begin
            r     <= (div_rsp.quo > DIV_W'(R_SAT)) ? R_SAT : div_rsp.quo[RSAT_W-1:0];
            state <= B_RAW;
          end
        end
        B_RAW: begin
          // Divide by 12800 as a shift by 9, then a reciprocal multiply for 25
          neg      <= rawnum[35];
          raw_prod <= rawmag[32:9] * RECIP_25;
          state    <= B_RAW_W;
        end
        B_RAW_W: begin
          raw   <= neg ? -$signed(raw_prod[48:29]) : $signed(raw_prod[48:29]);
          state <= B_MUL;
        end
        B_MUL: begin
          p1    <= $signed({1'b0, cfg.spo2_keep}) * smoothed;
          p2    <= $signed({1'b0, new_w}) * raw;
          state <= B_SUM;
        end
        B_SUM: begin
          smoothed <= ssum[35:16];
          state    <= B_OUT;
        end
        B_OUT: begin
          if (load) begin
            spo2_ok          <= valid_now;
            spo2_percent     <= valid_now ? held_rnd[14:8] : held;
            smoothed_spo2_q8 <= smoothed;
            raw_spo2_q8      <= comp ? raw : -20'sd256;
            red_acdc_q16     <= comp ? $signed({1'b0, rr}) : -19'sd65536;
            ir_acdc_q16      <= comp ? $signed({1'b0, ri}) : -19'sd65536;
            if (valid_now) begin
              held <= held_rnd[14:8];
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spo2_window_ratio_estimator.sv =====
// SpO2 ratio-of-ratios estimator, top level: config registers, front, queue, back.
// Depends on spo2_pkg, spo2_front, spo2_fifo, spo2_div and spo2_back.
// Front: takes one sample pair and runs it through the multiply / DC / deviation /
//   square / accumulate sequence before it takes the next, plus a push on window close.
// Back: per closed window, up to five divisions on the shared 64-step divider
//   and two 32-step square roots; a two-entry queue decouples them.
// Reset (synchronous, active high) clears DC trackers, sums, smoothing and out_valid.
`default_nettype none

module spo2_window_ratio_estimator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [17:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spo2_pkg::SAMPLE_W-1:0] red_sample,
  input  logic [spo2_pkg::SAMPLE_W-1:0] ir_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [6:0]                    spo2_percent,
  output logic                          spo2_ok,
  output logic signed [19:0]            smoothed_spo2_q8,
  output logic signed [19:0]            raw_spo2_q8,
  output logic signed [18:0]            red_acdc_q16,
  output logic signed [18:0]            ir_acdc_q16
);
  import spo2_pkg::*;

  cfg_t     cfg;
  job_t     push_job, pop_job;
  logic     push, pop, fifo_empty, fifo_full;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration registers; write them only while the block is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_samples <= 11'd50;
      cfg.dc_keep        <= 16'd62259;
      cfg.spo2_keep      <= 16'd52429;
      cfg.dc_min         <= 18'd1;
      cfg.acdc_clamp     <= 18'd131072;
      cfg.min_acdc       <= 18'd0;
      cfg.low_limit      <= 7'd30;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW:     cfg.window_samples <= cfg_data[10:0];
        REG_DC_KEEP:    cfg.dc_keep        <= cfg_data[15:0];
        REG_SPO2_KEEP:  cfg.spo2_keep      <= cfg_data[15:0];
        REG_DC_MIN:     cfg.dc_min         <= cfg_data;
        REG_ACDC_CLAMP: cfg.acdc_clamp     <= cfg_data;
        REG_MIN_ACDC:   cfg.min_acdc       <= cfg_data;
        REG_LOW_LIMIT:  cfg.low_limit      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Track DC and collect squared deviations per sample
  spo2_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red_sample (red_sample),
    .ir_sample  (ir_sample),
    .push       (push),
    .push_job   (push_job),
    .fifo_full  (fifo_full)
  );

  // Hold closed windows until the back end is free
  spo2_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  spo2_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Turn each window into ratios, SpO2 and the registered result
  spo2_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .fifo_empty       (fifo_empty),
    .fifo_job         (pop_job),
    .pop              (pop),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .spo2_percent     (spo2_percent),
    .spo2_ok          (spo2_ok),
    .smoothed_spo2_q8 (smoothed_spo2_q8),
    .raw_spo2_q8      (raw_spo2_q8),
    .red_acdc_q16     (red_acdc_q16),
    .ir_acdc_q16      (ir_acdc_q16)
  );

endmodule

`default_nettype wire

// ===== tb/spo2_result_checker.sv =====
// Watches the request and result channels of the SpO2 estimator and checks every result.
// Depends on spo2_pkg for register indexes; predicts windows from its own copy of state.
`timescale 1ns / 100ps

module spo2_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [17:0]        red_sample,
  input  logic [17:0]        ir_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [6:0]         spo2_percent,
  input  logic               spo2_ok,
  input  logic signed [19:0] smoothed_spo2_q8,
  input  logic signed [19:0] raw_spo2_q8,
  input  logic signed [18:0] red_acdc_q16,
  input  logic signed [18:0] ir_acdc_q16,
  output int                 errors,
  output int                 pending,
  output int                 windows_seen,
  output int                 windows_ok
);
  import spo2_pkg::*;

  typedef struct {
    logic [6:0]         pct;
    logic               ok;
    logic signed [19:0] smooth;
    logic signed [19:0] raw;
    logic signed [18:0] red;
    logic signed [18:0] ir;
  } window_result_t;

  window_result_t expected_windows[$];

  longint unsigned win_len, dc_keep, spo2_keep, dc_floor, clamp, min_ratio, low_limit;
  longint unsigned red_dc, ir_dc, red_sum, ir_sum, count;
  longint          smoothed;
  longint unsigned held;

  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic void track(input logic [17:0] s, input longint unsigned keep,
                                inout longint unsigned dc, inout longint unsigned sum);
    longint unsigned x, mag, dev, sq;
    x = longint'(s) << 16;
    dc = (dc * keep + x * (65536 - keep) + 32768) >> 16;
    mag = (x >= dc) ? x - dc : dc - x;
    dev = (mag + 128) >> 8;
    if (dev > 64'hFFFF_FFFF) dev = 64'hFFFF_FFFF;
    sq = dev * dev;
    sum = (sum > ~64'd0 - sq) ? ~64'd0 : sum + sq;
  endfunction

  function automatic longint unsigned acdc_ratio(longint unsigned sum, longint unsigned n,
                                                 longint unsigned dc);
    longint unsigned rms, r;
    rms = isqrt(sum / n);
    r = ((rms << 24) + (dc >> 1)) / dc;
    return (r > clamp) ? clamp : r;
  endfunction

  // Advance the predicted state by one request; return 1 when a window closes.
  function automatic bit predict_window(input logic [17:0] red_s, input logic [17:0] ir_s,
                                        output window_result_t res);
    longint unsigned w, rr, ri, r;
    longint          red_o, ir_o, raw_o, raw;
    bit              ok;
    track(red_s, dc_keep, red_dc, red_sum);
    track(ir_s, dc_keep, ir_dc, ir_sum);
    count++;
    w = win_len;
    if (w == 0) w = 1;
    if (w > WINDOW_MAX) w = WINDOW_MAX;
    if (count < w) return 0;
    red_o = -65536;
    ir_o = -65536;
    raw_o = -256;
    ok = 0;
    if (red_dc > (dc_floor << 16) && ir_dc > (dc_floor << 16) && ir_sum != 0) begin
      rr = acdc_ratio(red_sum, count, red_dc);
      ri = acdc_ratio(ir_sum, count, ir_dc);
      if (ri == 0) begin
        r = (rr == 0) ? 0 : (64'd64 << 16);
      end else begin
        r = ((rr << 16) + (ri >> 1)) / ri;
        if (r > (64'd64 << 16)) r = 64'd64 << 16;
      end
      raw = floor_div(358219776 - 1165 * longint'(r) + 6400, 12800);
      smoothed = floor_div(longint'(spo2_keep) * smoothed
                           + longint'(65536 - spo2_keep) * raw + 32768, 65536);
      if (smoothed > longint'(low_limit) * 256 && smoothed <= 25600
          && rr >= min_ratio && ri >= min_ratio) begin
        held = (smoothed + 128) / 256;
        ok = 1;
      end
      red_o = longint'(rr);
      ir_o = longint'(ri);
      raw_o = raw;
    end
    red_sum = 0;
    ir_sum = 0;
    count = 0;
    res.pct = held[6:0];
    res.ok = ok;
    res.smooth = smoothed[19:0];
    res.raw = raw_o[19:0];
    res.red = red_o[18:0];
    res.ir = ir_o[18:0];
    return 1;
  endfunction

  assign pending = expected_windows.size();

  always @(posedge clk) begin
    window_result_t res, exp_r;
    if (rst) begin
      win_len = 50; dc_keep = 62259; spo2_keep = 52429; dc_floor = 1;
      clamp = 131072; min_ratio = 0; low_limit = 30;
      red_dc = 0; ir_dc = 0; red_sum = 0; ir_sum = 0; count = 0;
      smoothed = 0; held = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW:     win_len = cfg_data[10:0];
          REG_DC_KEEP:    dc_keep = cfg_data[15:0];
          REG_SPO2_KEEP:  spo2_keep = cfg_data[15:0];
          REG_DC_MIN:     dc_floor = cfg_data;
          REG_ACDC_CLAMP: clamp = cfg_data;
          REG_MIN_ACDC:   min_ratio = cfg_data;
          REG_LOW_LIMIT:  low_limit = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (predict_window(red_sample, ir_sample, res)) expected_windows.push_back(res);
      end
      if (out_valid && !out_stall) begin
        windows_seen++;
        if (spo2_ok) windows_ok++;
        if (expected_windows.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, nothing expected (actual pct %0d ok %0d)",
                   $time, spo2_percent, spo2_ok);
        end else begin
          exp_r = expected_windows.pop_front();
          if (exp_r.pct !== spo2_percent || exp_r.ok !== spo2_ok
              || exp_r.smooth !== smoothed_spo2_q8 || exp_r.raw !== raw_spo2_q8
              || exp_r.red !== red_acdc_q16 || exp_r.ir !== ir_acdc_q16) begin
            errors++;
            $display("%0t: expected pct %0d ok %0d smooth %0d raw %0d red %0d ir %0d",
                     $time, exp_r.pct, exp_r.ok, exp_r.smooth, exp_r.raw, exp_r.red,
                     exp_r.ir);
            $display("%0t: actual   pct %0d ok %0d smooth %0d raw %0d red %0d ir %0d",
                     $time, spo2_percent, spo2_ok, smoothed_spo2_q8, raw_spo2_q8,
                     red_acdc_q16, ir_acdc_q16);
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    windows_seen = 0;
    windows_ok = 0;
  end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the SpO2 window ratio estimator.
// Depends on spo2_pkg, the estimator RTL and spo2_result_checker.
`timescale 1ns / 100ps

module tb_top;
  import spo2_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  // Idle wait at the end of each drain, after every expected window has come back.
  localparam int SETTLE_CYCLES = 1200;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = REG_WINDOW;
  logic [17:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [17:0] red_sample = 0;
  logic [17:0] ir_sample = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [6:0] spo2_percent;
  logic spo2_ok;
  logic signed [19:0] smoothed_spo2_q8, raw_spo2_q8;
  logic signed [18:0] red_acdc_q16, ir_acdc_q16;

  int errors, pending, windows_seen, windows_ok;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  int requests_sent = 0;

  // Shape of the current synthetic pulse waveform
  int dc_red, dc_ir, amp_red, amp_ir, phase;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  spo2_window_ratio_estimator uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .red_sample, .ir_sample,
    .out_valid, .out_stall, .spo2_percent, .spo2_ok,
    .smoothed_spo2_q8, .raw_spo2_q8, .red_acdc_q16, .ir_acdc_q16
  );

  spo2_result_checker checker_i (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .red_sample, .ir_sample,
    .out_valid, .out_stall, .spo2_percent, .spo2_ok,
    .smoothed_spo2_q8, .raw_spo2_q8, .red_acdc_q16, .ir_acdc_q16,
    .errors, .pending, .windows_seen, .windows_ok
  );

  // Receiver side: stall at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one request and hold it until accepted. The edge that accepts
  // it is the edge where the next request (or the idle) gets driven.
  task automatic send(input logic [17:0] red, input logic [17:0] ir);
    logic stalled;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    red_sample <= red;
    ir_sample <= ir;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    requests_sent++;
  endtask

  // Drop valid, then wait until every expected window has come back and the
  // back end has gone quiet, so registers can be written safely.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= 18'(value);
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [17:0] clip18(input int v);
    if (v < 0) return 18'h0;
    if (v > 262143) return 18'h3FFFF;
    return v[17:0];
  endfunction

  // Pick a new pulse shape: DC level, AC depth and a red/IR depth ratio
  // around the physiological band so most windows come out valid.
  task automatic new_pulse_shape();
    dc_ir = $urandom_range(1000, 200000);
    dc_red = $urandom_range(1000, 200000);
    amp_ir = dc_ir * $urandom_range(5, 60) / 1000;
    amp_red = dc_red * $urandom_range(5, 60) / 1000 * $urandom_range(40, 120) / 100;
    phase = $urandom_range(31);
  endtask

  task automatic send_pulse_sample();
    int tri_v;
    int mode;
    phase = (phase + 1) % 32;
    tri_v = (phase < 16) ? phase - 8 : 24 - phase;
    mode = $urandom_range(99);
    if (mode < 88) begin
      send(clip18(dc_red + amp_red * tri_v / 8 + int'($urandom_range(8)) - 4),
           clip18(dc_ir + amp_ir * tri_v / 8 + int'($urandom_range(8)) - 4));
    end else if (mode < 95) begin
      send(18'($urandom), 18'($urandom));     // raw noise over all bits
    end else begin
      send(($urandom_range(1)) ? 18'h3FFFF : 18'h0, 18'h0);   // dropout or saturation
    end
  endtask

  task automatic random_settings();
    write_reg(REG_WINDOW, ($urandom_range(9) == 0) ? $urandom_range(0, 2047)
                                                   : $urandom_range(1, 40));
    write_reg(REG_DC_KEEP, ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(55000, 65535));
    write_reg(REG_SPO2_KEEP, $urandom_range(0, 65535));
    write_reg(REG_DC_MIN, ($urandom_range(7) == 0) ? $urandom_range(0, 262143)
                                                   : $urandom_range(0, 2000));
    write_reg(REG_ACDC_CLAMP, ($urandom_range(3) == 0) ? $urandom_range(0, 131072)
                                                       : 131072);
    write_reg(REG_MIN_ACDC, ($urandom_range(3) == 0) ? $urandom_range(0, 8000) : 0);
    write_reg(REG_LOW_LIMIT, $urandom_range(0, 100));
    end_writes();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: single-sample windows over the field extremes
    write_reg(REG_WINDOW, 1);
    end_writes();
    send(18'h0, 18'h0);
    send(18'h3FFFF, 18'h3FFFF);
    send(18'h0, 18'h3FFFF);
    send(18'h3FFFF, 18'h0);
    send(18'h2AAAA, 18'h15555);
    send(18'h15555, 18'h2AAAA);
    drain();

    // Zero window length counts as one; DC tracks exactly with no retain,
    // so the IR deviation sum stays zero and the window is not computable
    write_reg(REG_WINDOW, 0);
    write_reg(REG_DC_KEEP, 0);
    end_writes();
    send(18'd5000, 18'd7000);
    send(18'd6000, 18'd7000);
    drain();

    // DC floor at its top: nothing is computable; clamp at zero; strict gates
    write_reg(REG_DC_KEEP, 65535);
    write_reg(REG_DC_MIN, 262143);
    write_reg(REG_WINDOW, 2);
    end_writes();
    send(18'h3FFFF, 18'h3FFFF);
    send(18'h1000, 18'h1000);
    drain();
    write_reg(REG_DC_MIN, 0);
    write_reg(REG_ACDC_CLAMP, 0);
    write_reg(REG_MIN_ACDC, 131072);
    write_reg(REG_LOW_LIMIT, 100);
    write_reg(REG_SPO2_KEEP, 0);
    end_writes();
    send(18'd9000, 18'd3000);
    send(18'd1000, 18'd8000);
    drain();

    // Oversized window saturates; shortening it mid-window closes on the next sample
    write_reg(REG_ACDC_CLAMP, 131072);
    write_reg(REG_MIN_ACDC, 0);
    write_reg(REG_LOW_LIMIT, 0);
    write_reg(REG_SPO2_KEEP, 65535);
    write_reg(REG_WINDOW, 2047);
    end_writes();
    repeat (5) send(18'($urandom), 18'($urandom));
    drain();
    write_reg(REG_WINDOW, 1);
    end_writes();
    send(18'd40000, 18'd50000);
    drain();

    // Random phases: receiver-heavy idling, sender-heavy idling, then none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 22 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        random_settings();
        new_pulse_shape();
        for (int n = 0; n < 50; n++) begin
          if ($urandom_range(39) == 0) new_pulse_shape();
          send_pulse_sample();
        end
        drain();
      end
    end

    $display("Sent %0d sample pairs over three stall mixes; %0d windows checked, %0d valid.",
             requests_sent, windows_seen, windows_ok);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
